// ----- src/imabd_pkg.sv -----
// Shared types, constants and decode tables for the IMA ADPCM block decoder.
`timescale 1ns / 1ps

package imabd_pkg;

  localparam int MAX_CHANNELS    = 2;
  localparam int GROUP_BYTES     = 4;
  localparam int HDR_BYTES_PER_CH = 4;
  localparam int SLOTS_PER_LANE  = 2 * GROUP_BYTES;
  localparam int SLOTS           = MAX_CHANNELS * SLOTS_PER_LANE;
  localparam int COUNT_W         = $clog2(SLOTS + 1);

  localparam logic [6:0] IDX_MAX = 7'd88;

  // configuration register indexes
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_BLOCK_ALIGN   = 2'd1;

  localparam logic signed [4:0] INDEX_ADJUST [0:15] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8,
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

  localparam logic [14:0] STEP_TABLE [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
    15'd29794, 15'd32767
  };

  // run of samples handed from the decode stage to the output buffer
  typedef struct packed {
    logic                      valid;
    logic [COUNT_W-1:0]        count;
    logic [SLOTS-1:0]          chan;
    logic [SLOTS-1:0][15:0]    samples;
  } load_t;

endpackage

// ----- src/imabd_nibble.sv -----
// One IMA ADPCM nibble decode: step lookup, delta, saturation, index update.
`timescale 1ns / 1ps

module imabd_nibble (
  input  logic [7:0]  idx,
  input  logic [15:0] pred,
  input  logic [3:0]  nib,
  output logic [15:0] pred_next,
  output logic [6:0]  idx_next
);

  logic [6:0]         idx_c;
  logic [14:0]        step;
  logic [16:0]        delta;
  logic signed [17:0] pred_x;
  logic signed [17:0] delta_x;
  logic signed [17:0] sum;
  logic signed [4:0]  adj;
  logic signed [9:0]  ix;

  always_comb begin
    idx_c = (idx > {1'b0, imabd_pkg::IDX_MAX}) ? imabd_pkg::IDX_MAX : idx[6:0];
    step  = imabd_pkg::STEP_TABLE[idx_c];
    delta = {5'b0, step[14:3]}
          + (nib[2] ? {2'b0, step} : 17'd0)
          + (nib[1] ? {3'b0, step[14:1]} : 17'd0)
          + (nib[0] ? {4'b0, step[14:2]} : 17'd0);
    pred_x  = {{2{pred[15]}}, pred};
    delta_x = {1'b0, delta};
    sum     = nib[3] ? (pred_x - delta_x) : (pred_x + delta_x);
    if (sum > 18'sd32767) begin
      pred_next = 16'h7FFF;
    end else if (sum < -18'sd32768) begin
      pred_next = 16'h8000;
    end else begin
      pred_next = sum[15:0];
    end
    adj = imabd_pkg::INDEX_ADJUST[nib];
    ix  = $signed({2'b00, idx}) + $signed({{5{adj[4]}}, adj});
    if (ix < 10'sd0) begin
      idx_next = 7'd0;
    end else if (ix > $signed({3'b000, imabd_pkg::IDX_MAX})) begin
      idx_next = imabd_pkg::IDX_MAX;
    end else begin
      idx_next = ix[6:0];
    end
  end

endmodule

// ----- src/imabd_front.sv -----
// Input stage, configuration, block/group tracking, channel state and group store.
`timescale 1ns / 1ps

module imabd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] data_byte
  input  logic                s_tlast,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                emit_free,
  output imabd_pkg::load_t    load
);

  localparam int SLOTS = imabd_pkg::SLOTS;

  logic [1:0]  chan_count;
  logic [15:0] block_align;

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        stage_eod;

  logic [15:0] block_offset;
  logic [15:0] pred [imabd_pkg::MAX_CHANNELS];
  logic [7:0]  step_idx [imabd_pkg::MAX_CHANNELS];
  logic [2:0]  lane_cnt [imabd_pkg::MAX_CHANNELS];
  logic [15:0] gsamp [SLOTS];

  logic        stereo;
  logic        cfg_bad;
  logic [3:0]  hdr_len;
  logic        in_hdr;
  logic        hdr_done;
  logic [15:0] rel;
  logic [2:0]  p;
  logic        lane;
  logic        grp_end;
  logic        blk_end;
  logic        flush;
  logic        need_emit;
  logic        go;
  logic [2:0]  cnt_base [imabd_pkg::MAX_CHANNELS];
  logic [2:0]  cnt_upd [imabd_pkg::MAX_CHANNELS];
  logic        wr;
  logic [2:0]  waddr;
  logic [2:0]  frames3;
  logic [3:0]  frames;
  logic [15:0] gs_view [SLOTS];
  logic [15:0] s0;
  logic [15:0] s1;
  logic [6:0]  i0;
  logic [6:0]  i1;
  logic        restart;

  imabd_nibble u_nib_lo (
    .idx       (step_idx[lane]),
    .pred      (pred[lane]),
    .nib       (stage_byte[3:0]),
    .pred_next (s0),
    .idx_next  (i0)
  );

  imabd_nibble u_nib_hi (
    .idx       ({1'b0, i0}),
    .pred      (s0),
    .nib       (stage_byte[7:4]),
    .pred_next (s1),
    .idx_next  (i1)
  );

  always_comb begin
    stereo   = (chan_count == 2'd2);
    hdr_len  = {chan_count, 2'b00};
    cfg_bad  = (chan_count == 2'd0) || (32'(chan_count) > imabd_pkg::MAX_CHANNELS)
            || (block_align < {12'b0, hdr_len});
    in_hdr   = (block_offset < {12'b0, hdr_len});
    hdr_done = in_hdr && (block_offset[3:0] == hdr_len - 4'd1);
    rel      = block_offset - {12'b0, hdr_len};
    p        = stereo ? rel[2:0] : {1'b0, rel[1:0]};
    lane     = in_hdr ? (stereo & block_offset[2]) : (stereo & p[2]);
    grp_end  = (p == (stereo ? 3'd7 : 3'd3));
    blk_end  = ({1'b0, block_offset} + 17'd1) >= {1'b0, block_align};
    restart  = blk_end || stage_eod;
    flush    = !in_hdr && (grp_end || restart);

    for (int l = 0; l < imabd_pkg::MAX_CHANNELS; l++) begin
      cnt_base[l] = (p == 3'd0) ? 3'd0 : lane_cnt[l];
    end
    wr    = (32'(cnt_base[lane]) < imabd_pkg::GROUP_BYTES);
    waddr = {lane, cnt_base[lane][1:0]};
    for (int l = 0; l < imabd_pkg::MAX_CHANNELS; l++) begin
      cnt_upd[l] = cnt_base[l] + {2'b0, (lane == l[0]) && wr};
    end
    frames3 = (stereo && (cnt_upd[1] < cnt_upd[0])) ? cnt_upd[1] : cnt_upd[0];
    frames  = {frames3, 1'b0};

    for (int i = 0; i < SLOTS; i++) begin
      if (wr && (3'(i >> 1) == waddr)) begin
        gs_view[i] = ((i & 1) != 0) ? s1 : s0;
      end else begin
        gs_view[i] = gsamp[i];
      end
    end

    need_emit = hdr_done || flush;
    go        = stage_valid && (!need_emit || emit_free);
    s_tready  = !stage_valid || go;

    load.valid   = go && !cfg_bad && need_emit;
    load.count   = '0;
    load.chan    = '0;
    load.samples = '0;
    if (in_hdr) begin
      load.count      = {3'b0, chan_count};
      load.samples[0] = pred[0];
      load.samples[1] = pred[1];
      load.chan[1]    = 1'b1;
    end else begin
      load.count = stereo ? {frames, 1'b0} : {1'b0, frames};
      for (int k = 0; k < SLOTS; k++) begin
        if (stereo) begin
          load.samples[k] = gs_view[4'(((k & 1) << 3) | (k >> 1))];
          load.chan[k]    = ((k & 1) != 0);
        end else begin
          load.samples[k] = gs_view[k];
        end
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count  <= 2'd1;
      block_align <= 16'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        imabd_pkg::REG_CHANNEL_COUNT: chan_count  <= cfg_data[1:0];
        imabd_pkg::REG_BLOCK_ALIGN:   block_align <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      stage_valid <= 1'b1;
    end else if (go) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_byte <= s_tdata;
      stage_eod  <= s_tlast;
    end
  end

  // block position and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      block_offset <= '0;
      for (int l = 0; l < imabd_pkg::MAX_CHANNELS; l++) begin
        pred[l]     <= '0;
        step_idx[l] <= '0;
        lane_cnt[l] <= '0;
      end
    end else if (go) begin
      if (cfg_bad) begin
        block_offset <= '0;
        for (int l = 0; l < imabd_pkg::MAX_CHANNELS; l++) lane_cnt[l] <= '0;
      end else begin
        block_offset <= restart ? 16'd0 : block_offset + 16'd1;
        if (in_hdr) begin
          case (block_offset[1:0])
            2'd0: pred[lane][7:0]  <= stage_byte;
            2'd1: pred[lane][15:8] <= stage_byte;
            2'd2: step_idx[lane]   <= stage_byte;
            default: ;
          endcase
          if (restart) begin
            for (int l = 0; l < imabd_pkg::MAX_CHANNELS; l++) lane_cnt[l] <= '0;
          end
        end else begin
          pred[lane]     <= s1;
          step_idx[lane] <= {1'b0, i1};
          for (int l = 0; l < imabd_pkg::MAX_CHANNELS; l++) begin
            lane_cnt[l] <= flush ? 3'd0 : cnt_upd[l];
          end
        end
      end
    end
  end

  // group sample store, two entries per data byte
  always_ff @(posedge clk) begin
    if (go && !cfg_bad && !in_hdr && wr) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (3'(i >> 1) == waddr) begin
          gsamp[i] <= ((i & 1) != 0) ? s1 : s0;
        end
      end
    end
  end

endmodule

// ----- src/imabd_emit.sv -----
// Output buffer: holds one run of samples and shifts them out one beat at a time.
`timescale 1ns / 1ps

module imabd_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  imabd_pkg::load_t              load,
  output logic                          emit_free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [15:0] sample
  output logic                          m_tuser,   // [0] channel
  output logic                          m_tlast
);

  logic [imabd_pkg::COUNT_W-1:0]            cnt;
  logic [imabd_pkg::SLOTS-1:0][15:0]        samples;
  logic [imabd_pkg::SLOTS-1:0]              chan;
  logic                                     beat;

  // free when empty or when the final beat of the run goes out this cycle
  assign emit_free = (cnt == '0) || ((cnt == imabd_pkg::COUNT_W'(1)) && m_tready);
  assign m_tvalid  = (cnt != '0);
  assign beat      = m_tvalid && m_tready;
  assign m_tdata   = samples[0];
  assign m_tuser   = chan[0];
  assign m_tlast   = (cnt == imabd_pkg::COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load.valid) begin
      cnt <= load.count;
    end else if (beat) begin
      cnt <= cnt - imabd_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      samples <= load.samples;
      chan    <= load.chan;
    end else if (beat) begin
      samples <= samples >> 16;
      chan    <= chan >> 1;
    end
  end

endmodule

// ----- src/ima_adpcm_block_decoder.sv -----
// Top level of the IMA ADPCM block decoder.
`timescale 1ns / 1ps

// Decodes a WAV IMA ADPCM data chunk fed one byte per beat. A byte is taken into
// an input register and decoded in the next cycle (both nibbles, chained), so bytes
// enter at one per cycle while no run of samples is pending. Header, group, block
// and stream ends hand a run of up to 16 samples to the output buffer, which sends
// one sample per cycle while m_tready is high; a byte that ends a run waits until
// the final beat of the previous run is taken. Sustained, the output bounds the byte
// rate, as each data byte yields two samples. A run loads from the byte in the
// input register. Configuration is taken at any time (cfg_ready is always high).

module ima_adpcm_block_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [15:0] sample
  output logic        m_tuser,    // [0] channel
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  imabd_pkg::load_t load;
  logic             emit_free;

  assign cfg_ready = 1'b1;

  imabd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .emit_free (emit_free),
    .load      (load)
  );

  imabd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .emit_free (emit_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- src/imabd_checker.sv -----
// Port-level checks for the IMA ADPCM block decoder, bound to the top level.
`timescale 1ns / 1ps

module imabd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // nothing is pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a run is sent without gaps until its last beat
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("gap inside a run of samples");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled output beat changed");

endmodule

bind ima_adpcm_block_decoder imabd_checker u_imabd_checker (.*);
